// ===== hw/rtl/chrc_pkg.sv =====
`default_nettype none

package chrc_pkg;

  localparam int unsigned RegionW  = 2;
  localparam int unsigned HoldW    = 12;
  localparam int unsigned WindowW  = 13;
  localparam int unsigned PressW   = 3;
  localparam int unsigned DivW     = 3;
  localparam int unsigned PadW     = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 13;

  typedef enum logic [1:0] {
    CMD_SEL_FALL  = 2'd0,
    CMD_SEL_RISE  = 2'd1,
    CMD_RST_PRESS = 2'd2,
    CMD_TICK      = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    COMBO_NONE  = 2'd0,
    COMBO_RESET = 2'd1,
    COMBO_CLOCK = 2'd2
  } combo_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_INITIAL_REGION = 2'd0,
    REG_HOLD_TICKS     = 2'd1,
    REG_WINDOW_TICKS   = 2'd2,
    REG_PRESSES_NEEDED = 2'd3
  } cfg_idx_e;

  localparam logic [RegionW-1:0] RegionJapan    = 2'd0;
  localparam logic [RegionW-1:0] RegionAmericas = 2'd1;
  localparam logic [RegionW-1:0] RegionEurope   = 2'd2;

  localparam logic [HoldW-1:0]   HoldTicksRst     = 12'd1000;
  localparam logic [WindowW-1:0] WindowTicksRst   = 13'd3000;
  localparam logic [PressW-1:0]  PressesNeededRst = 3'd3;
  localparam logic [RegionW-1:0] InitRegionRst    = RegionAmericas;

  localparam logic [HoldW-1:0]   HoldMax   = {HoldW{1'b1}};
  localparam logic [WindowW-1:0] WindowMax = {WindowW{1'b1}};
  localparam logic [PressW-1:0]  PressMax  = {PressW{1'b1}};

  localparam logic [DivW-1:0] DivNormal    = 3'd7;
  localparam logic [DivW-1:0] DivOverclock = 3'd5;

  // pad bit positions
  localparam int unsigned BtnA = 0;
  localparam int unsigned BtnB = 1;
  localparam int unsigned BtnS = 2;
  localparam int unsigned BtnC = 3;

  localparam logic [PadW-1:0] PadAll      = 4'b1111;
  localparam logic [PadW-1:0] PadAStart   = 4'b0101;

  typedef struct packed {
    logic [RegionW-1:0] initial_region;
    logic [HoldW-1:0]   hold_ticks;
    logic [WindowW-1:0] window_ticks;
    logic [PressW-1:0]  presses_needed;
  } cfg_t;

  typedef struct packed {
    logic               load;
    logic [RegionW-1:0] value;
  } region_load_t;

  typedef struct packed {
    logic [RegionW-1:0] region;
    logic               ntsc_level;
    logic               export_level;
    logic [DivW-1:0]    clock_divisor;
    logic               overclock_on;
    logic               reset_pulse;
    logic               halt_pulse;
    logic               save_region;
    logic [PadW-1:0]    buttons;
  } result_t;

  // stored code 3 means nothing, fall back to americas
  function automatic logic [RegionW-1:0] load_region(input logic [RegionW-1:0] r);
    logic [RegionW-1:0] v;
    v = (r == 2'd3) ? RegionAmericas : r;
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/chrc_if.sv =====
`default_nettype none

interface chrc_evt_if import chrc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic       line_ab;
  logic       line_sc;

  modport source (output valid, output command, output line_ab, output line_sc,
                  input ready);
  modport sink   (input valid, input command, input line_ab, input line_sc,
                  output ready);
endinterface

interface chrc_res_if import chrc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RegionW-1:0] region;
  logic               ntsc_level;
  logic               export_level;
  logic [DivW-1:0]    clock_divisor;
  logic               overclock_on;
  logic               reset_pulse;
  logic               halt_pulse;
  logic               save_region;
  logic [PadW-1:0]    buttons;

  modport source (output valid, output region, output ntsc_level, output export_level,
                  output clock_divisor, output overclock_on, output reset_pulse,
                  output halt_pulse, output save_region, output buttons,
                  input ready);
  modport sink   (input valid, input region, input ntsc_level, input export_level,
                  input clock_divisor, input overclock_on, input reset_pulse,
                  input halt_pulse, input save_region, input buttons,
                  output ready);
endinterface

interface chrc_cfg_if import chrc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/chrc_cfg.sv =====
`default_nettype none

module chrc_cfg import chrc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                wr_valid_i,
  input  wire logic [CfgIdxW-1:0]  wr_index_i,
  input  wire logic [CfgDataW-1:0] wr_data_i,
  output logic                     wr_ready_o,
  output cfg_t                     cfg_o,
  output region_load_t             region_load_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign wr_ready_o = 1'b1;
  assign wr_en      = wr_valid_i;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (cfg_idx_e'(wr_index_i))
        REG_INITIAL_REGION: cfg_d.initial_region = wr_data_i[RegionW-1:0];
        REG_HOLD_TICKS:     cfg_d.hold_ticks     = wr_data_i[HoldW-1:0];
        REG_WINDOW_TICKS:   cfg_d.window_ticks   = wr_data_i[WindowW-1:0];
        REG_PRESSES_NEEDED: cfg_d.presses_needed = wr_data_i[PressW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{initial_region: InitRegionRst, hold_ticks: HoldTicksRst,
                 window_ticks: WindowTicksRst, presses_needed: PressesNeededRst};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o               = cfg_q;
  assign region_load_o.load  = wr_en && (cfg_idx_e'(wr_index_i) == REG_INITIAL_REGION);
  assign region_load_o.value = load_region(wr_data_i[RegionW-1:0]);

endmodule

`default_nettype wire

// ===== hw/rtl/chrc_core.sv =====
`default_nettype none

module chrc_core import chrc_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         accept_i,
  input  wire logic [1:0]   command_i,
  input  wire logic         line_ab_i,
  input  wire logic         line_sc_i,
  input  wire cfg_t         cfg_i,
  input  wire region_load_t region_load_i,
  output result_t           result_o
);

  logic [PadW-1:0]    pad_q, pad_d;
  logic [HoldW-1:0]   hold_q, hold_d;
  combo_e             held_q, held_d;
  logic [PressW-1:0]  press_q, press_d;
  logic [WindowW-1:0] win_q, win_d;
  logic [RegionW-1:0] region_q, region_d;
  logic               oc_q, oc_d;

  logic   ab_pressed, sc_pressed;
  logic   rst_p, halt_p, save_p;
  combo_e combo;
  logic [HoldW-1:0] hold_base;

  assign ab_pressed = ~line_ab_i;
  assign sc_pressed = ~line_sc_i;

  always_comb begin
    if (pad_q == PadAll) begin
      combo = COMBO_RESET;
    end else if (pad_q == PadAStart) begin
      combo = COMBO_CLOCK;
    end else begin
      combo = COMBO_NONE;
    end
    hold_base = (combo != held_q) ? '0 : hold_q;
  end

  always_comb begin
    pad_d    = pad_q;
    hold_d   = hold_q;
    held_d   = held_q;
    press_d  = press_q;
    win_d    = win_q;
    region_d = region_q;
    oc_d     = oc_q;
    rst_p    = 1'b0;
    halt_p   = 1'b0;
    save_p   = 1'b0;

    case (cmd_e'(command_i))
      CMD_SEL_FALL: begin
        pad_d[BtnA] = ab_pressed;
        pad_d[BtnS] = sc_pressed;
      end
      CMD_SEL_RISE: begin
        pad_d[BtnB] = ab_pressed;
        pad_d[BtnC] = sc_pressed;
      end
      CMD_RST_PRESS: begin
        if (press_q != PressMax) begin
          press_d = press_q + 1'b1;
        end
        if (press_q == '0) begin
          win_d = '0;
        end
      end
      CMD_TICK: begin
        if (combo != COMBO_NONE) begin
          held_d = combo;
          hold_d = hold_base;
          // counter sticks at full scale, no further fire
          if (hold_base != HoldMax) begin
            hold_d = hold_base + 1'b1;
            if (hold_d == cfg_i.hold_ticks) begin
              if (combo == COMBO_RESET) begin
                rst_p   = 1'b1;
                press_d = '0;
              end else begin
                oc_d   = ~oc_q;
                halt_p = 1'b1;
              end
            end
          end
        end else begin
          held_d = COMBO_NONE;
          hold_d = '0;
          if (win_q >= cfg_i.window_ticks) begin
            press_d = '0;
          end else if (press_q >= cfg_i.presses_needed) begin
            region_d = (region_q >= RegionEurope) ? RegionJapan : region_q + 1'b1;
            oc_d     = 1'b0;
            save_p   = 1'b1;
            rst_p    = 1'b1;
            press_d  = '0;
          end
          if (win_q != WindowMax) begin
            win_d = win_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_q    <= '0;
      hold_q   <= '0;
      held_q   <= COMBO_NONE;
      press_q  <= '0;
      win_q    <= '0;
      region_q <= InitRegionRst;
      oc_q     <= 1'b0;
    end else if (region_load_i.load) begin
      region_q <= region_load_i.value;
    end else if (accept_i) begin
      pad_q    <= pad_d;
      hold_q   <= hold_d;
      held_q   <= held_d;
      press_q  <= press_d;
      win_q    <= win_d;
      region_q <= region_d;
      oc_q     <= oc_d;
    end
  end

  // result reflects the state after this item
  always_comb begin
    result_o.region        = region_d;
    result_o.ntsc_level    = (region_d != RegionEurope);
    result_o.export_level  = (region_d != RegionJapan);
    result_o.clock_divisor = oc_d ? DivOverclock : DivNormal;
    result_o.overclock_on  = oc_d;
    result_o.reset_pulse   = rst_p;
    result_o.halt_pulse    = halt_p;
    result_o.save_region   = save_p;
    result_o.buttons       = pad_d;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/console_hotkey_region_controller.sv =====
// Console hotkey and region controller. Each event item (select edge with the two
// pad line levels, reset-button press, or 1 ms tick) yields exactly one result item
// showing region, jumper levels, clock divisor and the one-shot reset, halt and save
// flags. One item is taken per clock: the whole state update is combinational
// compare and counter logic that loads a result register, and a new item is accepted
// while the previous result waits, as long as that result is taken in the same cycle.
// Configuration writes are always ready and take effect on the next cycle; writing
// initial_region also loads the current region.
`default_nettype none

module console_hotkey_region_controller import chrc_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  chrc_evt_if.sink   in_i,
  chrc_res_if.source out_o,
  chrc_cfg_if.sink   cfg_i
);

  cfg_t         cfg;
  region_load_t region_load;
  result_t      result, res_q;
  logic         out_valid_q;
  logic         in_accept;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_accept  = in_i.valid && in_i.ready;

  chrc_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wr_valid_i    (cfg_i.valid),
    .wr_index_i    (cfg_i.index),
    .wr_data_i     (cfg_i.data),
    .wr_ready_o    (cfg_i.ready),
    .cfg_o         (cfg),
    .region_load_o (region_load)
  );

  chrc_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_accept),
    .command_i     (in_i.command),
    .line_ab_i     (in_i.line_ab),
    .line_sc_i     (in_i.line_sc),
    .cfg_i         (cfg),
    .region_load_i (region_load),
    .result_o      (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= result;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.region        = res_q.region;
  assign out_o.ntsc_level    = res_q.ntsc_level;
  assign out_o.export_level  = res_q.export_level;
  assign out_o.clock_divisor = res_q.clock_divisor;
  assign out_o.overclock_on  = res_q.overclock_on;
  assign out_o.reset_pulse   = res_q.reset_pulse;
  assign out_o.halt_pulse    = res_q.halt_pulse;
  assign out_o.save_region   = res_q.save_region;
  assign out_o.buttons       = res_q.buttons;

endmodule

`default_nettype wire

// ===== hw/rtl/chrc_checker.sv =====
`default_nettype none

module chrc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic       overclock_on_i,
  input wire logic [2:0] clock_divisor_i,
  input wire logic       reset_pulse_i,
  input wire logic       halt_pulse_i,
  input wire logic       save_region_i
);

  // a stalled result stays up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // region change always resets the console and drops the overclock
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && save_region_i |-> reset_pulse_i && !overclock_on_i)
    else $error("save without reset or with overclock");

  // hotkey and region actions are exclusive per item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && halt_pulse_i |-> !reset_pulse_i && !save_region_i)
    else $error("halt together with reset or save");

  // divisor tracks the overclock flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (overclock_on_i && clock_divisor_i == 3'd5)
                 || (!overclock_on_i && clock_divisor_i == 3'd7))
    else $error("divisor out of step with overclock flag");

endmodule

bind console_hotkey_region_controller chrc_checker u_chrc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .overclock_on_i  (out_o.overclock_on),
  .clock_divisor_i (out_o.clock_divisor),
  .reset_pulse_i   (out_o.reset_pulse),
  .halt_pulse_i    (out_o.halt_pulse),
  .save_region_i   (out_o.save_region)
);

`default_nettype wire

// ===== tb/tb_console_hotkey_region_controller.sv =====
`default_nettype none

module tb_console_hotkey_region_controller;
  import chrc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SqueezeCycles = 300;
  localparam int unsigned ItemsPerRound = 70;
  localparam int unsigned RandomRounds  = 8;
  localparam int unsigned LongRun       = 30;
  localparam logic [RegionW-1:0] RegionInvalid = 2'd3;

  typedef struct packed {
    cmd_e command;
    logic ab;
    logic sc;
  } pad_event_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  chrc_evt_if evt_if ();
  chrc_res_if res_if ();
  chrc_cfg_if cfg_if ();

  console_hotkey_region_controller i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (evt_if),
    .out_o (res_if),
    .cfg_i (cfg_if)
  );

  always #4 clk_i = ~clk_i;

  // shadow of the controller: settings and state
  logic [RegionW-1:0] init_region_cfg;
  logic [HoldW-1:0]   hold_cfg;
  logic [WindowW-1:0] window_cfg;
  logic [PressW-1:0]  presses_cfg;

  logic [PadW-1:0]    pad_q;
  logic [HoldW-1:0]   hold_q;
  combo_e             combo_q;
  logic [PressW-1:0]  presses_q;
  logic [WindowW-1:0] window_q;
  logic [RegionW-1:0] region_q;
  logic               overclock_q;

  pad_event_t pending_events[$];
  result_t    expected_results[$];

  int unsigned mismatches;
  int unsigned events_taken;
  int unsigned resets_seen;
  int unsigned halts_seen;
  int unsigned saves_seen;
  int unsigned settings_written;
  int unsigned idle_cycles;

  logic calm;         // no idling on either side
  logic squeeze_req;  // ask the receiver for one long hold-off

  function automatic result_t advance_console(input pad_event_t ev);
    result_t r;
    combo_e  combo;
    logic    fire;
    r = '0;
    case (ev.command)
      CMD_SEL_FALL: begin
        pad_q[BtnA] = ~ev.ab;
        pad_q[BtnS] = ~ev.sc;
      end
      CMD_SEL_RISE: begin
        pad_q[BtnB] = ~ev.ab;
        pad_q[BtnC] = ~ev.sc;
      end
      CMD_RST_PRESS: begin
        if (presses_q != PressMax) presses_q++;
        // first press of a burst opens the window
        if (presses_q == PressW'(1)) window_q = '0;
      end
      default: begin
        if (pad_q == PadAll) combo = COMBO_RESET;
        else if (pad_q == PadAStart) combo = COMBO_CLOCK;
        else combo = COMBO_NONE;
        if (combo != COMBO_NONE) begin
          // window timer pauses while a combination is held
          fire = 1'b0;
          if (combo != combo_q) begin
            combo_q = combo;
            hold_q = '0;
          end
          if (hold_q != HoldMax) begin
            hold_q++;
            fire = (hold_q == hold_cfg);
          end
          if (fire) begin
            if (combo == COMBO_RESET) begin
              r.reset_pulse = 1'b1;
              presses_q = '0;
            end else begin
              overclock_q = ~overclock_q;
              r.halt_pulse = 1'b1;
            end
          end
        end else begin
          combo_q = COMBO_NONE;
          hold_q = '0;
          if (window_q >= window_cfg) begin
            presses_q = '0;
          end else if (presses_q >= presses_cfg) begin
            region_q = (region_q >= RegionEurope) ? RegionJapan : region_q + 2'd1;
            overclock_q = 1'b0;
            r.save_region = 1'b1;
            r.reset_pulse = 1'b1;
            presses_q = '0;
          end
          if (window_q != WindowMax) window_q++;
        end
      end
    endcase
    r.region        = region_q;
    r.ntsc_level    = (region_q != RegionEurope);
    r.export_level  = (region_q != RegionJapan);
    r.clock_divisor = overclock_q ? DivOverclock : DivNormal;
    r.overclock_on  = overclock_q;
    r.buttons       = pad_q;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    if (calm) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(8, 40);
    return $urandom_range(0, 2);
  endfunction

  task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // event driver
  pad_event_t  offered;
  int unsigned send_gap;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      evt_if.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (evt_if.valid && evt_if.ready) begin
        expected_results.push_back(advance_console(offered));
        events_taken++;
      end
      if (!evt_if.valid || evt_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          evt_if.valid <= 1'b0;
        end else if (pending_events.size() > 0) begin
          offered = pending_events.pop_front();
          evt_if.valid   <= 1'b1;
          evt_if.command <= offered.command;
          evt_if.line_ab <= offered.ab;
          evt_if.line_sc <= offered.sc;
          send_gap = pick_gap();
        end else begin
          evt_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  int unsigned stall_left;
  int unsigned squeeze_left;
  logic        squeeze_done;
  result_t     want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t ns: result item with nothing expected, region %0d buttons %0h",
                   $time, res_if.region, res_if.buttons);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("region", want.region, res_if.region);
          check_field("ntsc_level", want.ntsc_level, res_if.ntsc_level);
          check_field("export_level", want.export_level, res_if.export_level);
          check_field("clock_divisor", want.clock_divisor, res_if.clock_divisor);
          check_field("overclock_on", want.overclock_on, res_if.overclock_on);
          check_field("reset_pulse", want.reset_pulse, res_if.reset_pulse);
          check_field("halt_pulse", want.halt_pulse, res_if.halt_pulse);
          check_field("save_region", want.save_region, res_if.save_region);
          check_field("buttons", want.buttons, res_if.buttons);
        end
        if (res_if.reset_pulse === 1'b1) resets_seen++;
        if (res_if.halt_pulse === 1'b1) halts_seen++;
        if (res_if.save_region === 1'b1) saves_seen++;
      end
      if (squeeze_req && !squeeze_done) begin
        squeeze_left = SqueezeCycles;
        squeeze_done = 1'b1;
      end
      if (squeeze_left > 0) begin
        squeeze_left--;
        res_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((evt_if.valid && evt_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t ns: no progress for %0d cycles", $time, idle_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic queue_event(input cmd_e c, input logic ab, input logic sc);
    pad_event_t ev;
    ev.command = c;
    ev.ab = ab;
    ev.sc = sc;
    pending_events.push_back(ev);
  endtask

  // two select edges that leave the pad bits at the given pattern
  task automatic press_pad(input logic [PadW-1:0] pattern);
    queue_event(CMD_SEL_FALL, ~pattern[BtnA], ~pattern[BtnS]);
    queue_event(CMD_SEL_RISE, ~pattern[BtnB], ~pattern[BtnC]);
  endtask

  task automatic queue_ticks(input int unsigned n);
    repeat (n) queue_event(CMD_TICK, 1'($urandom()), 1'($urandom()));
  endtask

  task automatic queue_scenario();
    int unsigned     pick;
    int unsigned     n;
    logic [PadW-1:0] pattern;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      case ($urandom_range(0, 3))
        0, 1:    pattern = PadAll;
        2:       pattern = PadAStart;
        default: pattern = PadW'($urandom());
      endcase
      press_pad(pattern);
      queue_ticks($urandom_range(0, int'(hold_cfg) + 3));
    end else if (pick < 6) begin
      press_pad(PadW'($urandom()));
      queue_ticks($urandom_range(0, 4));
    end else if (pick < 9) begin
      if ($urandom_range(0, 3) != 0) press_pad('0);
      n = $urandom_range(1, 8);
      repeat (n) begin
        queue_event(CMD_RST_PRESS, 1'($urandom()), 1'($urandom()));
        if ($urandom_range(0, 3) == 0) queue_ticks(1);
      end
      queue_ticks($urandom_range(0, int'(window_cfg) + 3));
    end else begin
      queue_event(cmd_e'($urandom_range(0, 3)), 1'($urandom()), 1'($urandom()));
    end
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_events.size() > 0 || evt_if.valid || expected_results.size() > 0)
      @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_setting(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_INITIAL_REGION: begin
        init_region_cfg = value[RegionW-1:0];
        region_q = (init_region_cfg == RegionInvalid) ? RegionAmericas : init_region_cfg;
      end
      REG_HOLD_TICKS:     hold_cfg = value[HoldW-1:0];
      REG_WINDOW_TICKS:   window_cfg = value[WindowW-1:0];
      default:            presses_cfg = value[PressW-1:0];
    endcase
    settings_written++;
    @(negedge clk_i);
  endtask

  task automatic apply_settings(input logic [RegionW-1:0] region, input logic [HoldW-1:0] hold,
                                input logic [WindowW-1:0] window,
                                input logic [PressW-1:0] presses);
    wait_idle();
    write_setting(REG_INITIAL_REGION, CfgDataW'(region));
    write_setting(REG_HOLD_TICKS, CfgDataW'(hold));
    write_setting(REG_WINDOW_TICKS, CfgDataW'(window));
    write_setting(REG_PRESSES_NEEDED, CfgDataW'(presses));
  endtask

  initial begin
    int unsigned start_size;
    rst_ni         = 1'b0;
    evt_if.valid   = 1'b0;
    evt_if.command = CMD_SEL_FALL;
    evt_if.line_ab = 1'b1;
    evt_if.line_sc = 1'b1;
    res_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = REG_INITIAL_REGION;
    cfg_if.data    = '0;
    calm           = 1'b0;
    squeeze_req    = 1'b0;
    squeeze_done   = 1'b0;
    squeeze_left   = 0;
    stall_left     = 0;
    mismatches     = 0;
    events_taken   = 0;
    resets_seen    = 0;
    halts_seen     = 0;
    saves_seen     = 0;
    settings_written = 0;
    idle_cycles    = 0;

    init_region_cfg = InitRegionRst;
    hold_cfg        = HoldTicksRst;
    window_cfg      = WindowTicksRst;
    presses_cfg     = PressesNeededRst;
    pad_q           = '0;
    hold_q          = '0;
    combo_q         = COMBO_NONE;
    presses_q       = '0;
    window_q        = '0;
    region_q        = InitRegionRst;
    overclock_q     = 1'b0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset values: a short hold that does not fire, press count saturating
    press_pad(PadAll);
    queue_ticks(1);
    queue_event(CMD_SEL_FALL, 1'b1, 1'b1);
    repeat (8) queue_event(CMD_RST_PRESS, 1'b0, 1'b1);
    queue_ticks(1);

    // stored code with no region, both hotkeys firing, region advance
    apply_settings(RegionInvalid, 12'd2, 13'd4, 3'd2);
    press_pad(PadAll);
    queue_ticks(2);
    queue_event(CMD_SEL_RISE, 1'b1, 1'b1);
    queue_ticks(2);
    queue_event(CMD_SEL_FALL, 1'b1, 1'b1);
    queue_event(CMD_RST_PRESS, 1'b1, 1'b0);
    queue_event(CMD_RST_PRESS, 1'b1, 1'b1);
    queue_ticks(1);

    for (int unsigned round = 0; round < RandomRounds; round++) begin
      case (round)
        0:       apply_settings(RegionJapan, 12'd1, 13'd1, 3'd1);
        1:       apply_settings(RegionEurope, 12'd3, 13'd20, PressMax);
        2:       apply_settings(RegionInvalid, '0, '0, '0);
        3:       apply_settings(RegionAmericas, 12'd2, 13'd12, '0);
        default: apply_settings(RegionW'($urandom_range(0, 3)), HoldW'($urandom_range(1, 8)),
                                WindowW'($urandom_range(1, 40)),
                                PressW'($urandom_range(1, 7)));
      endcase
      calm = (round == 6);
      start_size = pending_events.size();
      while (pending_events.size() - start_size < ItemsPerRound) queue_scenario();
      if (round == 5) squeeze_req = 1'b1;
    end

    // long holds: counting on after a one-tick hold fired, then a hold too long to fire
    calm = 1'b1;
    apply_settings(RegionEurope, 12'd1, WindowMax, PressMax);
    press_pad(PadAll);
    queue_ticks(LongRun);
    apply_settings(RegionJapan, HoldMax, 13'd30, 3'd2);
    press_pad(PadAStart);
    queue_ticks(LongRun);

    wait_idle();
    repeat (4) @(negedge clk_i);
    if (expected_results.size() != 0) begin
      $display("%0t ns: %0d results never arrived", $time, expected_results.size());
      mismatches++;
    end
    $display("covered %0d event items under %0d register writes, incl. long holds",
             events_taken, settings_written);
    $display("seen %0d console resets, %0d divider changes, %0d region saves, %0d mismatches",
             resets_seen, halts_seen, saves_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
